@@ hdl/imq_pkg.sv @@
// Package of shared types and constants for the indexed min priority queue.
`default_nettype none
package imq_pkg;
  localparam int unsigned Capacity = 256;
  localparam int unsigned IdW      = 8;
  localparam int unsigned PosW     = 9;
  localparam int unsigned KeyW     = 32;

  localparam logic [1:0] CmdPush   = 2'd0;
  localparam logic [1:0] CmdPop    = 2'd1;
  localparam logic [1:0] CmdChange = 2'd2;
  localparam logic [1:0] CmdQuery  = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StEmpty   = 2'd1;
  localparam logic [1:0] StAbsent  = 2'd2;
  localparam logic [1:0] StPresent = 2'd3;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone, OpLatch, OpRdSlot, OpRdKey, OpWrSlot, OpWrPos,
    OpClrPos, OpWrKey, OpMove, OpSetPos, OpCntInc, OpCntDec, OpStatus
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [1:0]       sel;   // result field selector for OpStatus
    logic [PosW-1:0]  apos;  // slot address
    logic [1:0]       st;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic            id_present;
    logic [PosW-1:0] id_pos;
    logic [PosW-1:0] cnt;
    logic [IdW-1:0]  rd_id;   // registered heap slot read
    logic [KeyW-1:0] rd_key;  // registered key read
  } stat_t;
endpackage
`default_nettype wire

@@ hdl/indexed_min_priority_queue.sv @@
// Top level of the indexed binary min-heap priority queue.
// One request (push, pop, change key, query) is taken when start is high and busy is
// low; its single result appears for one cycle with done_o, in the same cycle that busy
// falls, and the next request can be taken at the end of that cycle. A query or a refused
// request takes no sift; a sift adds time per level climbed and per level descended, plus
// a sift-down setup, because the slot and key memories are read one entry per cycle with
// registered data. The longest request is a change key at the root of a full heap.
// The receiver cannot stall the result.
`default_nettype none
module indexed_min_priority_queue import imq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      command_i,
  input  wire logic [IdW-1:0]  item_id_i,
  input  wire logic [KeyW-1:0] key_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [IdW-1:0]       popped_id_o,
  output logic [KeyW-1:0]      popped_key_o,
  output logic                 top_valid_o,
  output logic [IdW-1:0]       top_id_o,
  output logic [KeyW-1:0]      top_key_o,
  output logic                 item_present_o,
  output logic [KeyW-1:0]      item_key_o,
  output logic [PosW-1:0]      count_o
);
  cmd_t            cmd;
  stat_t           stat;
  logic [IdW-1:0]  id_a, cur_id;
  logic [KeyW-1:0] key_a, cur_key;
  logic            rd_pos;

  imq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .stat_i(stat),
    .cur_id_i(cur_id), .cur_key_i(cur_key), .cmd_o(cmd),
    .id_a_o(id_a), .key_a_o(key_a), .rd_pos_o(rd_pos)
  );

  imq_datapath u_dp (
    .clk_i, .rst_ni, .start_i(start), .command_i, .item_id_i, .key_i,
    .id_a_i(id_a), .key_a_i(key_a), .rd_pos_i(rd_pos), .cmd_i(cmd),
    .stat_o(stat), .cur_id_o(cur_id), .cur_key_o(cur_key),
    .done_o, .status_o, .popped_id_o, .popped_key_o, .top_valid_o, .top_id_o,
    .top_key_o, .item_present_o, .item_key_o, .count_o
  );
endmodule
`default_nettype wire

@@ hdl/imq_datapath.sv @@
// Datapath: slot, position and key memories, count and result registers.
`default_nettype none
module imq_datapath import imq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [1:0]      command_i,
  input  wire logic [IdW-1:0]  item_id_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic [IdW-1:0]  id_a_i,     // id operand chosen by controller
  input  wire logic [KeyW-1:0] key_a_i,
  input  wire logic            rd_pos_i,   // read position of id_a
  input  wire cmd_t            cmd_i,
  output stat_t                stat_o,
  output logic [IdW-1:0]       cur_id_o,
  output logic [KeyW-1:0]      cur_key_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [IdW-1:0]       popped_id_o,
  output logic [KeyW-1:0]      popped_key_o,
  output logic                 top_valid_o,
  output logic [IdW-1:0]       top_id_o,
  output logic [KeyW-1:0]      top_key_o,
  output logic                 item_present_o,
  output logic [KeyW-1:0]      item_key_o,
  output logic [PosW-1:0]      count_o
);
  logic [IdW-1:0]  slot_mem [Capacity+1];
  logic [KeyW-1:0] key_mem  [Capacity];
  logic [PosW-1:0] pos_mem  [Capacity];
  logic [Capacity-1:0] pos_vld_q;

  logic [1:0]      cmd_q;
  logic [IdW-1:0]  id_q;
  logic [KeyW-1:0] key_q;
  logic [PosW-1:0] cnt_q;
  logic [IdW-1:0]  rd_id_q;
  logic [KeyW-1:0] rd_key_q;
  logic [PosW-1:0] pos_q;
  logic            idpres_q;

  assign cur_id_o  = id_q;
  assign cur_key_o = key_q;

  // Request latch and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cmd_q <= CmdQuery;
    end else begin
      if (start_i && cmd_i.op == OpLatch) cmd_q <= command_i;
      if (cmd_i.op == OpCntInc) cnt_q <= cnt_q + PosW'(1);
      if (cmd_i.op == OpCntDec) cnt_q <= cnt_q - PosW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && cmd_i.op == OpLatch) begin
      id_q  <= item_id_i;
      key_q <= key_i;
    end
  end

  // Memories, read data registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpRdSlot) rd_id_q <= slot_mem[cmd_i.apos];
    if (cmd_i.op == OpRdKey)  rd_key_q <= key_mem[id_a_i];
    if (cmd_i.op == OpWrSlot || cmd_i.op == OpMove) slot_mem[cmd_i.apos] <= id_a_i;
    if (cmd_i.op == OpWrKey)  key_mem[id_a_i] <= key_a_i;
    if (cmd_i.op == OpWrPos || cmd_i.op == OpMove || cmd_i.op == OpSetPos)
      pos_mem[id_a_i] <= cmd_i.apos;
    if (rd_pos_i) begin
      pos_q    <= pos_mem[id_a_i];
    end
  end

  // Presence bits, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q <= '0;
      idpres_q  <= 1'b0;
    end else begin
      if (rd_pos_i) idpres_q <= pos_vld_q[id_a_i];
      if (cmd_i.op == OpWrPos || cmd_i.op == OpMove || cmd_i.op == OpSetPos)
        pos_vld_q[id_a_i] <= 1'b1;
      if (cmd_i.op == OpClrPos) pos_vld_q[id_a_i] <= 1'b0;
    end
  end

  assign stat_o = '{cmd: cmd_q, id_present: idpres_q, id_pos: pos_q, cnt: cnt_q,
                    rd_id: rd_id_q, rd_key: rd_key_q};

  // Result registers; sel picks which field to load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.op == OpStatus && cmd_i.sel == 2'd3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpStatus) begin
      unique case (cmd_i.sel)
        2'd0: begin
          status_o     <= cmd_i.st;
          popped_id_o  <= '0;
          popped_key_o <= '0;
        end
        2'd1: begin
          popped_id_o  <= id_a_i;
          popped_key_o <= key_a_i;
        end
        2'd2: begin
          top_valid_o <= cnt_q != '0;
          top_id_o    <= (cnt_q != '0) ? rd_id_q : '0;
          top_key_o   <= (cnt_q != '0) ? rd_key_q : '0;
        end
        default: begin
          item_present_o <= idpres_q;
          item_key_o     <= idpres_q ? rd_key_q : '0;
          count_o        <= cnt_q;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/imq_ctrl.sv @@
// Controller: sequences push, pop, change-key and query over the datapath.
`default_nettype none
module imq_ctrl import imq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire stat_t           stat_i,
  input  wire logic [IdW-1:0]  cur_id_i,
  input  wire logic [KeyW-1:0] cur_key_i,
  output cmd_t                 cmd_o,
  output logic [IdW-1:0]       id_a_o,
  output logic [KeyW-1:0]      key_a_o,
  output logic                 rd_pos_o
);
  typedef enum logic [25:0] {
    SIdle    = 26'd1 << 0,  SChk     = 26'd1 << 1,  SDisp   = 26'd1 << 2,
    SPush    = 26'd1 << 3,  SPopRd   = 26'd1 << 4,  SPopK   = 26'd1 << 5,
    SPopLast = 26'd1 << 6,  SUpPar   = 26'd1 << 7,  SUpPk   = 26'd1 << 8,
    SUpCmp   = 26'd1 << 9,  SPlace   = 26'd1 << 10, SDnSet  = 26'd1 << 11,
    SDnId    = 26'd1 << 12, SDnKey   = 26'd1 << 13, SDnL    = 26'd1 << 14,
    SDnLk    = 26'd1 << 15, SDnR     = 26'd1 << 16, SDnRk   = 26'd1 << 17,
    SDnCmp   = 26'd1 << 18, SRes0    = 26'd1 << 19, STopRd  = 26'd1 << 20,
    STopK    = 26'd1 << 21, SItPos   = 26'd1 << 22, SItK    = 26'd1 << 23,
    SFin     = 26'd1 << 24, SDone    = 26'd1 << 25
  } state_e;

  state_e          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;      // hole position
  logic [PosW-1:0] org_q, org_d;      // slot whose id starts the sift-down
  logic [PosW-1:0] ch_q, ch_d;        // left child position
  logic [IdW-1:0]  mv_q, mv_d;        // moving id
  logic [KeyW-1:0] mk_q, mk_d;        // moving key
  logic [IdW-1:0]  lid_q, lid_d;      // left child / parent id
  logic [KeyW-1:0] lk_q, lk_d;
  logic            dn_q, dn_d;        // after up: do down
  logic [1:0]      st_q, st_d;
  logic [IdW-1:0]  pid_q, pid_d;
  logic [KeyW-1:0] pk_q, pk_d;
  logic [PosW:0]   c2;

  assign busy_o = state_q != SIdle;
  assign c2 = {pos_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; org_q <= org_d; ch_q <= ch_d; mv_q <= mv_d; mk_q <= mk_d;
    lid_q <= lid_d; lk_q <= lk_d; dn_q <= dn_d; st_q <= st_d; pid_q <= pid_d;
    pk_q <= pk_d;
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    pos_d = pos_q; org_d = org_q; ch_d = ch_q; mv_d = mv_q; mk_d = mk_q;
    lid_d = lid_q; lk_d = lk_q; dn_d = dn_q; st_d = st_q; pid_d = pid_q; pk_d = pk_q;
    cmd_o = '{op: OpNone, sel: 2'd0, apos: '0, st: StOk};
    id_a_o = cur_id_i;
    key_a_o = cur_key_i;
    rd_pos_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        cmd_o.op = OpLatch;
        if (start_i) state_d = SChk;
      end
      SChk: begin
        rd_pos_o = 1'b1;
        state_d = SDisp;
      end
      SDisp: begin
        st_d = StOk; pid_d = '0; pk_d = '0;
        unique case (stat_i.cmd)
          CmdPush: begin
            if (stat_i.cnt == PosW'(Capacity)) begin
              st_d = StAbsent; state_d = SRes0;
            end else if (stat_i.id_present) begin
              st_d = StPresent; state_d = SRes0;
            end else begin
              cmd_o.op = OpWrKey;
              mv_d = cur_id_i; mk_d = cur_key_i;
              pos_d = stat_i.cnt + PosW'(1);
              dn_d = 1'b0;
              state_d = SPush;
            end
          end
          CmdPop: begin
            if (stat_i.cnt == '0) begin
              st_d = StEmpty; state_d = SRes0;
            end else begin
              cmd_o = '{op: OpRdSlot, sel: 2'd0, apos: PosW'(1), st: StOk};
              state_d = SPopRd;
            end
          end
          CmdChange: begin
            if (!stat_i.id_present) begin
              st_d = StAbsent; state_d = SRes0;
            end else begin
              cmd_o.op = OpWrKey;
              mv_d = cur_id_i; mk_d = cur_key_i;
              pos_d = stat_i.id_pos; org_d = stat_i.id_pos;
              dn_d = 1'b1;
              state_d = SUpPar;
            end
          end
          default: state_d = SRes0;
        endcase
      end
      SPush: begin
        cmd_o.op = OpCntInc;
        state_d = SUpPar;
      end
      SPopRd: begin
        id_a_o = stat_i.rd_id;
        cmd_o.op = OpRdKey;
        state_d = SPopK;
      end
      SPopK: begin
        pid_d = stat_i.rd_id; pk_d = stat_i.rd_key;
        id_a_o = stat_i.rd_id;
        cmd_o.op = OpClrPos;
        state_d = SPopLast;
      end
      // The last id becomes the mover with the hole at the root.
      SPopLast: begin
        cmd_o.op = OpCntDec;
        org_d = stat_i.cnt;
        pos_d = PosW'(1);
        dn_d = 1'b0;
        if (stat_i.cnt == PosW'(1)) state_d = SRes0;
        else state_d = SDnSet;
      end
      // Sift up: compare mover with parent.
      SUpPar: begin
        if (pos_q == PosW'(1)) begin
          state_d = SPlace;
        end else begin
          cmd_o = '{op: OpRdSlot, sel: 2'd0, apos: pos_q >> 1, st: StOk};
          state_d = SUpPk;
        end
      end
      SUpPk: begin
        id_a_o = stat_i.rd_id;
        lid_d = stat_i.rd_id;
        cmd_o.op = OpRdKey;
        state_d = SUpCmp;
      end
      SUpCmp: begin
        if (mk_q < stat_i.rd_key) begin
          id_a_o = lid_q;
          cmd_o = '{op: OpMove, sel: 2'd0, apos: pos_q, st: StOk};
          pos_d = pos_q >> 1;
          state_d = SUpPar;
        end else begin
          state_d = SPlace;
        end
      end
      // Drop the mover into the hole; a change key then sifts down from its start slot.
      SPlace: begin
        id_a_o = mv_q;
        cmd_o = '{op: OpMove, sel: 2'd0, apos: pos_q, st: StOk};
        if (dn_q) begin
          dn_d = 1'b0;
          pos_d = org_q;
          state_d = SDnSet;
        end else begin
          state_d = SRes0;
        end
      end
      // Sift-down entry: the mover is the id held at org, with its key.
      SDnSet: begin
        cmd_o = '{op: OpRdSlot, sel: 2'd0, apos: org_q, st: StOk};
        state_d = SDnId;
      end
      SDnId: begin
        id_a_o = stat_i.rd_id;
        mv_d = stat_i.rd_id;
        cmd_o.op = OpRdKey;
        state_d = SDnKey;
      end
      SDnKey: begin
        mk_d = stat_i.rd_key;
        state_d = SDnL;
      end
      // Sift down: read the left child, then the right one where it exists.
      SDnL: begin
        if (c2 > {1'b0, stat_i.cnt}) begin
          state_d = SPlace;
        end else begin
          cmd_o = '{op: OpRdSlot, sel: 2'd0, apos: c2[PosW-1:0], st: StOk};
          state_d = SDnLk;
        end
      end
      SDnLk: begin
        id_a_o = stat_i.rd_id;
        lid_d = stat_i.rd_id;
        ch_d = c2[PosW-1:0];
        cmd_o.op = OpRdKey;
        state_d = SDnR;
      end
      SDnR: begin
        lk_d = stat_i.rd_key;
        if ({1'b0, ch_q} + (PosW+1)'(1) > {1'b0, stat_i.cnt}) begin
          state_d = SDnCmp;
        end else begin
          cmd_o = '{op: OpRdSlot, sel: 2'd0, apos: ch_q + PosW'(1), st: StOk};
          state_d = SDnRk;
        end
      end
      SDnRk: begin
        id_a_o = stat_i.rd_id;
        cmd_o.op = OpRdKey;
        state_d = SDnCmp;
      end
      SDnCmp: begin
        // The right child is taken only when it exists and is strictly smaller.
        if (({1'b0, ch_q} + (PosW+1)'(1) <= {1'b0, stat_i.cnt}) &&
            (stat_i.rd_key < lk_q)) begin
          if (mk_q < stat_i.rd_key) begin
            state_d = SPlace;
          end else begin
            id_a_o = stat_i.rd_id;
            cmd_o = '{op: OpMove, sel: 2'd0, apos: pos_q, st: StOk};
            pos_d = ch_q + PosW'(1);
            state_d = SDnL;
          end
        end else if (mk_q < lk_q) begin
          state_d = SPlace;
        end else begin
          id_a_o = lid_q;
          cmd_o = '{op: OpMove, sel: 2'd0, apos: pos_q, st: StOk};
          pos_d = ch_q;
          state_d = SDnL;
        end
      end
      // Result assembly.
      SRes0: begin
        cmd_o = '{op: OpStatus, sel: 2'd0, apos: '0, st: st_q};
        state_d = STopRd;
      end
      STopRd: begin
        id_a_o = pid_q; key_a_o = pk_q;
        cmd_o = '{op: OpStatus, sel: 2'd1, apos: '0, st: StOk};
        state_d = STopK;
      end
      STopK: begin
        cmd_o = '{op: OpRdSlot, sel: 2'd0, apos: PosW'(1), st: StOk};
        state_d = SItPos;
      end
      SItPos: begin
        id_a_o = stat_i.rd_id;
        cmd_o.op = OpRdKey;
        state_d = SItK;
      end
      SItK: begin
        cmd_o = '{op: OpStatus, sel: 2'd2, apos: '0, st: StOk};
        rd_pos_o = 1'b1;
        state_d = SFin;
      end
      SFin: begin
        cmd_o.op = OpRdKey;
        state_d = SDone;
      end
      SDone: begin
        cmd_o = '{op: OpStatus, sel: 2'd3, apos: '0, st: StOk};
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end
endmodule
`default_nettype wire

@@ test/imq_checker.sv @@
// Checker for the indexed min priority queue: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module imq_checker import imq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            busy_i,
  input  wire logic [1:0]      command_i,
  input  wire logic [IdW-1:0]  item_id_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic            done_i,
  input  wire logic [1:0]      status_i,
  input  wire logic [IdW-1:0]  popped_id_i,
  input  wire logic [KeyW-1:0] popped_key_i,
  input  wire logic            top_valid_i,
  input  wire logic [IdW-1:0]  top_id_i,
  input  wire logic [KeyW-1:0] top_key_i,
  input  wire logic            item_present_i,
  input  wire logic [KeyW-1:0] item_key_i,
  input  wire logic [PosW-1:0] count_i,
  output int                   err_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [1:0]      status;
    logic [IdW-1:0]  popped_id;
    logic [KeyW-1:0] popped_key;
    logic            top_valid;
    logic [IdW-1:0]  top_id;
    logic [KeyW-1:0] top_key;
    logic            item_present;
    logic [KeyW-1:0] item_key;
    logic [PosW-1:0] count;
  } answer_t;

  // Shadow copy of the heap.
  logic [IdW-1:0]  slot_id [1:Capacity];
  logic [PosW-1:0] id_slot [0:Capacity-1];
  logic [KeyW-1:0] id_key  [0:Capacity-1];
  logic [PosW-1:0] fill;

  answer_t answers_due[$];
  int      mismatches;

  initial begin
    for (int i = 0; i < Capacity; i++) begin
      id_slot[i] = '0;
      id_key[i]  = '0;
      slot_id[i+1] = '0;
    end
    fill = '0;
    mismatches = 0;
    pending_o = 0;
  end

  assign err_count_o = mismatches;

  function automatic void put(input logic [PosW-1:0] p, input logic [IdW-1:0] id);
    slot_id[p] = id;
    id_slot[id] = p;
  endfunction

  function automatic void bubble_up(input logic [PosW-1:0] p_in);
    logic [PosW-1:0] p;
    logic [IdW-1:0]  mover;
    p = p_in;
    mover = slot_id[p];
    while (p > 1 && id_key[mover] < id_key[slot_id[p >> 1]]) begin
      put(p, slot_id[p >> 1]);
      p = p >> 1;
    end
    put(p, mover);
  endfunction

  function automatic void bubble_down(input logic [PosW-1:0] p_in);
    logic [PosW:0]   p, c;
    logic [IdW-1:0]  mover;
    p = {1'b0, p_in};
    mover = slot_id[p];
    c = {p[PosW-1:0], 1'b0};
    while (c <= {1'b0, fill}) begin
      if (c + 1'b1 <= {1'b0, fill} && id_key[slot_id[c + 1'b1]] < id_key[slot_id[c]]) c++;
      if (id_key[mover] < id_key[slot_id[c]]) break;
      put(c[PosW-1:0] >> 0 == c[PosW-1:0] ? p[PosW-1:0] : p[PosW-1:0], slot_id[c]);
      p = c;
      c = {p[PosW-1:0], 1'b0};
    end
    put(p[PosW-1:0], mover);
  endfunction

  // Apply one request to the shadow heap and form its result.
  function automatic answer_t heap_apply(input logic [1:0] cmd, input logic [IdW-1:0] id,
                                         input logic [KeyW-1:0] key);
    answer_t a;
    logic [IdW-1:0]  gone;
    logic [PosW-1:0] p;
    a = '0;
    a.status = StOk;
    case (cmd)
      CmdPush: begin
        if (fill >= Capacity) a.status = StAbsent;
        else if (id_slot[id] != 0) a.status = StPresent;
        else begin
          id_key[id] = key;
          fill = fill + PosW'(1);
          put(fill, id);
          bubble_up(fill);
        end
      end
      CmdPop: begin
        if (fill == 0) a.status = StEmpty;
        else begin
          gone = slot_id[1];
          a.popped_id = gone;
          a.popped_key = id_key[gone];
          put(PosW'(1), slot_id[fill]);
          id_slot[gone] = '0;
          fill = fill - PosW'(1);
          if (fill > 0) bubble_down(PosW'(1));
        end
      end
      CmdChange: begin
        if (id_slot[id] == 0) a.status = StAbsent;
        else begin
          p = id_slot[id];
          id_key[id] = key;
          bubble_up(p);
          bubble_down(p);
        end
      end
      default: ;
    endcase
    if (fill > 0) begin
      a.top_valid = 1'b1;
      a.top_id = slot_id[1];
      a.top_key = id_key[slot_id[1]];
    end
    if (id_slot[id] != 0) begin
      a.item_present = 1'b1;
      a.item_key = id_key[id];
    end
    a.count = fill;
    return a;
  endfunction

  task automatic field_check(input string name, input logic [KeyW-1:0] want,
                             input logic [KeyW-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Requests are predicted when taken; results are checked as they appear.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (start_i && !busy_i)
        answers_due.push_back(heap_apply(command_i, item_id_i, key_i));
      if (done_i) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no request waiting", $realtime);
        end else begin
          want = answers_due.pop_front();
          field_check("status", KeyW'(want.status), KeyW'(status_i));
          field_check("popped_id", KeyW'(want.popped_id), KeyW'(popped_id_i));
          field_check("popped_key", want.popped_key, popped_key_i);
          field_check("top_valid", KeyW'(want.top_valid), KeyW'(top_valid_i));
          field_check("top_id", KeyW'(want.top_id), KeyW'(top_id_i));
          field_check("top_key", want.top_key, top_key_i);
          field_check("item_present", KeyW'(want.item_present), KeyW'(item_present_i));
          field_check("item_key", want.item_key, item_key_i);
          field_check("count", KeyW'(want.count), KeyW'(count_i));
        end
      end
    end
    pending_o = answers_due.size();
  end
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench top for the indexed min priority queue: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import imq_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [1:0]      command_i = CmdQuery;
  logic [IdW-1:0]  item_id_i = '0;
  logic [KeyW-1:0] key_i = '0;
  logic            done_o;
  logic [1:0]      status_o;
  logic [IdW-1:0]  popped_id_o;
  logic [KeyW-1:0] popped_key_o;
  logic            top_valid_o;
  logic [IdW-1:0]  top_id_o;
  logic [KeyW-1:0] top_key_o;
  logic            item_present_o;
  logic [KeyW-1:0] item_key_o;
  logic [PosW-1:0] count_o;
  int              err_count;
  int              pending;
  int unsigned     cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  indexed_min_priority_queue i_dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .item_id_i, .key_i, .done_o,
    .status_o, .popped_id_o, .popped_key_o, .top_valid_o, .top_id_o, .top_key_o,
    .item_present_o, .item_key_o, .count_o
  );

  imq_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .item_id_i, .key_i,
    .done_i(done_o), .status_i(status_o), .popped_id_i(popped_id_o),
    .popped_key_i(popped_key_o), .top_valid_i(top_valid_o), .top_id_i(top_id_o),
    .top_key_i(top_key_o), .item_present_i(item_present_o), .item_key_i(item_key_o),
    .count_i(count_o), .err_count_o(err_count), .pending_o(pending)
  );

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return KeyW'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Present one request from a falling edge and hold it until it is taken.
  task automatic send(input logic [1:0] cmd, input logic [IdW-1:0] id,
                      input logic [KeyW-1:0] key);
    logic taken;
    int   gap;
    command_i = cmd;
    item_id_i = id;
    key_i = key;
    start = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
      @(negedge clk_i);
    end
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if (gap > 0) begin
      start = 1'b0;
      command_i = 2'($urandom());
      item_id_i = IdW'($urandom());
      key_i = $urandom();
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    int mode;
    int roll;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed requests: extremes, equal keys and all error cases but the full-heap push.
    send(CmdPop, 8'd0, '0);
    send(CmdChange, 8'd9, 32'd5);
    send(CmdQuery, 8'd255, '0);
    send(CmdPush, 8'd0, '1);
    send(CmdPush, 8'd255, '0);
    send(CmdPush, 8'd7, '0);
    send(CmdPush, 8'd0, 32'd3);
    send(CmdPush, 8'd128, 32'h8000_0000);
    send(CmdQuery, 8'd7, '1);
    send(CmdQuery, 8'd3, '1);
    send(CmdChange, 8'd0, '0);
    send(CmdChange, 8'd255, '1);
    send(CmdChange, 8'd9, '0);
    send(CmdChange, 8'd128, 32'h8000_0000);
    send(CmdPop, 8'd255, '1);
    send(CmdPop, 8'd0, '0);
    send(CmdPop, 8'd0, '0);
    send(CmdPop, 8'd0, '0);
    send(CmdPop, 8'd0, '0);
    send(CmdQuery, 8'd0, '0);

    // Fill the heap to capacity, then push once more into the full heap.
    for (int i = 0; i < Capacity; i++) send(CmdPush, IdW'(i), pick_key());
    send(CmdPush, 8'd17, 32'd1);
    send(CmdChange, 8'd200, '0);

    // Random requests in phases that lean towards growth, shrinkage or a mix.
    mode = 1;
    for (int n = 0; n < 1270; n++) begin
      if (n % 150 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (mode == 0)
        send(roll < 65 ? CmdPush : roll < 75 ? CmdPop : roll < 90 ? CmdChange : CmdQuery,
             IdW'($urandom()), pick_key());
      else if (mode == 1)
        send(roll < 20 ? CmdPush : roll < 70 ? CmdPop : roll < 85 ? CmdChange : CmdQuery,
             IdW'($urandom()), pick_key());
      else
        send(2'($urandom_range(0, 3)), IdW'($urandom()), pick_key());
    end
    start = 1'b0;

    // Drain the outstanding results and let the block settle.
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
